[design/sltd_pkg.sv]
// Package for the sync/length/trailer deframer.
// Holds the framing byte constants and the controller/datapath interface structs.
// No dependencies.
package sltd_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;
    localparam logic [7:0] TRAILER     = 8'h5A;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int FLEN_W  = 7;

    // Commands from controller to datapath
    typedef struct packed {
        logic len_load;   // capture length byte
        logic cnt_clr;    // clear byte counter
        logic cnt_inc;    // advance byte counter
        logic wr_en;      // write payload byte into store
        logic rd_en;      // read store at counter
        logic out_load;   // load result register
        logic out_empty;  // result is the empty-frame marker
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic sync1;      // rx byte is first sync
        logic sync2;      // rx byte is second sync
        logic trailer;    // rx byte is trailer
        logic rx_zero;    // rx byte is zero
        logic len_ok;     // stored length within limit
        logic len_zero;   // stored length is zero
        logic cnt_end;    // counter at last byte of payload
        logic out_free;   // result register can take a new item
    } t_sts;

endpackage

[design/sltd_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module sltd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/sltd_ctrl.sv]
// Deframer controller: frame hunt, payload count and playback sequencing.
// Depends on sltd_pkg (t_cmd, t_sts).
module sltd_ctrl
    import sltd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_rx_valid,
    input  t_sts i_sts,
    output logic o_rx_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_HUNT,
        S_SYNC2,
        S_LEN,
        S_PAY,
        S_TRL,
        S_RD,
        S_LD,
        S_EMPTY
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   rx_ready;
    logic   rx_acc;

    // Input is taken in every receive state, held off during playback
    always_comb begin
        case (r_state)
            S_HUNT, S_SYNC2, S_LEN, S_PAY, S_TRL: rx_ready = 1'b1;
            default:                              rx_ready = 1'b0;
        endcase
    end

    assign rx_acc     = i_rx_valid && rx_ready;
    assign o_rx_ready = rx_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_HUNT: begin
                if (rx_acc && i_sts.sync1) begin
                    n_state = S_SYNC2;
                end
            end
            S_SYNC2: begin
                if (rx_acc) begin
                    n_state = i_sts.sync2 ? S_LEN : S_HUNT;
                end
            end
            S_LEN: begin
                if (rx_acc) begin
                    o_cmd.len_load = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    n_state        = i_sts.rx_zero ? S_TRL : S_PAY;
                end
            end
            S_PAY: begin
                if (rx_acc) begin
                    // oversize frames are counted through but not stored
                    o_cmd.wr_en   = i_sts.len_ok;
                    o_cmd.cnt_inc = 1'b1;
                    if (i_sts.cnt_end) begin
                        n_state = S_TRL;
                    end
                end
            end
            S_TRL: begin
                if (rx_acc) begin
                    if (i_sts.trailer && i_sts.len_ok) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = i_sts.len_zero ? S_EMPTY : S_RD;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_LD;
            end
            S_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.cnt_end) begin
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                        n_state       = S_RD;
                    end
                end
            end
            S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_empty = 1'b1;
                    n_state         = S_HUNT;
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/sltd_dpath.sv]
// Deframer datapath: byte compares, length and counter, payload store, result register.
// Depends on sltd_pkg and sltd_ram.
module sltd_dpath
    import sltd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    input  logic               i_res_ready,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic               o_res_valid,
    output logic [BYTE_W-1:0]  o_payload_byte,
    output logic [INDEX_W-1:0] o_byte_index,
    output logic [FLEN_W-1:0]  o_frame_length,
    output logic               o_empty_frame,
    output logic               o_last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]         r_len;
    logic [7:0]         r_cnt;
    logic               r_valid;
    logic [BYTE_W-1:0]  r_payload;
    logic [INDEX_W-1:0] r_index;
    logic [FLEN_W-1:0]  r_flen;
    logic               r_empty;
    logic               r_last;
    logic [BYTE_W-1:0]  ram_rd_data;
    logic               cnt_end;
    logic               out_free;

    // counter sits on the last payload byte when cnt + 1 == len
    assign cnt_end  = ({1'b0, r_cnt} + 9'd1) == {1'b0, r_len};
    assign out_free = !r_valid || i_res_ready;

    // Status to controller
    always_comb begin
        o_sts.sync1    = (i_rx_byte == SYNC_FIRST);
        o_sts.sync2    = (i_rx_byte == SYNC_SECOND);
        o_sts.trailer  = (i_rx_byte == TRAILER);
        o_sts.rx_zero  = (i_rx_byte == 8'd0);
        o_sts.len_ok   = (r_len <= 8'(MAX_PAYLOAD));
        o_sts.len_zero = (r_len == 8'd0);
        o_sts.cnt_end  = cnt_end;
        o_sts.out_free = out_free;
    end

    // Length and byte counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.len_load) begin
            r_len <= i_rx_byte;
        end
        if (i_cmd.cnt_clr) begin
            r_cnt <= 8'd0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 8'd1;
        end
    end

    // Payload store
    sltd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_cnt[AW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_payload <= i_cmd.out_empty ? '0 : ram_rd_data;
            r_index   <= i_cmd.out_empty ? '0 : r_cnt[INDEX_W-1:0];
            r_flen    <= r_len[FLEN_W-1:0];
            r_empty   <= i_cmd.out_empty;
            r_last    <= i_cmd.out_empty || cnt_end;
        end
    end

    assign o_res_valid    = r_valid;
    assign o_payload_byte = r_payload;
    assign o_byte_index   = r_index;
    assign o_frame_length = r_flen;
    assign o_empty_frame  = r_empty;
    assign o_last         = r_last;

endmodule

[design/sync_length_trailer_deframer_core.sv]
// Channel  | valid        | ready        | payload
// rx in    | i_rx_valid   | o_rx_ready   | i_rx_byte
// res out  | o_res_valid  | i_res_ready  | o_payload_byte, o_byte_index, o_frame_length,
//          |              |              | o_empty_frame, o_last
//
// Receive: one byte per cycle through sync, length, payload and trailer.
// Playback after a good trailer: a store read, then a result register load, for each
// payload byte, and one marker load for an empty frame; input is held off meanwhile.
// Result stalls hold playback; reset (synchronous, active low) returns to the hunt.
// Top level of the deframer; depends on sltd_pkg, sltd_ctrl, sltd_dpath, sltd_ram.
module sync_length_trailer_deframer_core
    import sltd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [BYTE_W-1:0]  o_payload_byte,
    output logic [INDEX_W-1:0] o_byte_index,
    output logic [FLEN_W-1:0]  o_frame_length,
    output logic               o_empty_frame,
    output logic               o_last
);

    t_cmd cmd;
    t_sts sts;

    sltd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_sts      (sts),
        .o_rx_ready (o_rx_ready),
        .o_cmd      (cmd)
    );

    sltd_dpath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx_byte),
        .i_res_ready    (i_res_ready),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_res_valid    (o_res_valid),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length),
        .o_empty_frame  (o_empty_frame),
        .o_last         (o_last)
    );

`ifndef SYNTHESIS
    // store is written only with an accepted byte
    a_wr_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_en |-> (i_rx_valid && o_rx_ready))
        else $error("payload store written without an accepted item");

    // a payload result always lies inside its frame
    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_empty_frame) |-> ({1'b0, o_byte_index} < o_frame_length))
        else $error("byte index beyond frame length");

    // input stays held off while a run item other than the last is waiting
    a_run_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_last) |-> !o_rx_ready)
        else $error("input taken in the middle of a playback run");
`endif

endmodule
